[rtl/core/lfdc_pkg.sv]
// shared types and constants of the line follow drive controller
// used by the channel interfaces and the top level; depends on nothing
package lfdc_pkg;

	typedef enum logic [2:0] {
		PH_RUN,
		PH_DWELL,
		PH_EXIT,
		PH_OB_STOP,
		PH_OB_SPIN,
		PH_OB_ARC,
		PH_OB_SEARCH,
		PH_OB_BACK
	} phase_t;

	localparam logic [1:0] MODE_RUN     = 2'd0;
	localparam logic [1:0] MODE_AVOID   = 2'd1;
	localparam logic [1:0] MODE_STATION = 2'd2;

	localparam logic [1:0] HEAD_FWD   = 2'd0;
	localparam logic [1:0] HEAD_LEFT  = 2'd1;
	localparam logic [1:0] HEAD_RIGHT = 2'd2;

	localparam logic REG_RUN_SPEED = 1'b0;
	localparam logic REG_STOP_TIME = 1'b1;

	localparam logic [9:0] RUN_SPEED_RESET = 10'd300;
	localparam logic [5:0] STOP_TIME_RESET = 6'd3;

	localparam logic [15:0] SEARCH_LIMIT_TICKS = 16'd4000;
	localparam logic [8:0]  DWELL_TICKS        = 9'd180;
	localparam logic [8:0]  DWELL_RUN_MAX      = 9'd511;
	localparam logic [11:0] HOLDOFF_TICKS      = 12'd2000;
	localparam logic [11:0] HOLDOFF_SAT        = 12'd2001;
	localparam logic [5:0]  SONAR_PERIOD       = 6'd31;
	localparam logic [1:0]  HITS_NEEDED        = 2'd3;
	localparam logic [15:0] EXIT_TICKS         = 16'd400;
	localparam logic [15:0] OB_STOP_TICKS      = 16'd200;
	localparam logic [15:0] OB_SPIN_TICKS      = 16'd450;
	localparam logic [15:0] OB_ARC_TICKS       = 16'd350;
	localparam logic [15:0] OB_BACK_TICKS      = 16'd100;
	localparam logic [15:0] TICKS_PER_SEC      = 16'd1000;
	localparam logic [11:0] NEAR_MIN_MM        = 12'd10;
	localparam logic [11:0] NEAR_MAX_MM        = 12'd150;

	localparam logic signed [11:0] OB_SPIN_DRIVE = 12'sd180;
	localparam logic signed [11:0] OB_OUTER      = 12'sd250;
	localparam logic signed [11:0] OB_INNER      = 12'sd130;
	localparam logic signed [11:0] OB_BACK_DRIVE = 12'sd150;
	localparam logic signed [7:0]  TURN_GAIN     = 8'sd25;

	// floor(x/10) == (x*6554)>>16 for x below 16384
	localparam logic [25:0] DIV10_RECIP = 26'd6554;
	localparam logic [12:0] SLOW_NUM    = 13'd7;

endpackage

[rtl/core/lfdc_channels.sv]
// valid/ready channel interfaces for sensor ticks and drive results
// depends on lfdc_pkg
interface lfdc_tick_if;
	import lfdc_pkg::*;
	logic        valid;
	logic        ready;
	logic [4:0]  line_sensors;
	logic [11:0] distance_mm;

	modport source (output valid, output line_sensors, output distance_mm, input ready);
	modport sink (input valid, input line_sensors, input distance_mm, output ready);
endinterface

interface lfdc_drive_if;
	import lfdc_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [11:0] left_drive;
	logic signed [11:0] right_drive;
	logic [1:0]         heading;
	logic [1:0]         car_mode;
	logic [15:0]        stations_seen;

	modport source (output valid, output left_drive, output right_drive, output heading,
		output car_mode, output stations_seen, input ready);
	modport sink (input valid, input left_drive, input right_drive, input heading,
		input car_mode, input stations_seen, output ready);
endinterface

[rtl/core/line_follow_drive_controller.sv]
// line follow drive controller: one sensor tick in, one drive result out
// an accepted tick is held in the input register, then its result in the result register
// throughput: one tick per cycle, set by the single-pass update between the
// input register and the result register; both sides may stall freely
// reset: arst_n clears all tracking, sonar, station and phase state and loads
// run_speed 300 and stop_time_s 3; depends on lfdc_pkg and lfdc_channels
module line_follow_drive_controller (
	input  logic         clk,
	input  logic         arst_n,
	lfdc_tick_if.sink    tick,
	lfdc_drive_if.source drive,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import lfdc_pkg::*;

	logic [9:0]  run_speed_q;
	logic [5:0]  stop_time_q;

	logic        valid_s1;
	logic [4:0]  sensors_s1;
	logic [11:0] distance_s1;

	logic               valid_s2;
	logic signed [11:0] left_s2;
	logic signed [11:0] right_s2;
	logic [1:0]         heading_s2;
	logic [1:0]         mode_s2;
	logic [15:0]        stations_s2;

	phase_t             phase_q, phase_d;
	logic [15:0]        phase_timer_q, phase_timer_d;
	logic signed [3:0]  prev_err_q, prev_err_d;
	logic [11:0]        holdoff_q, holdoff_d;
	logic [5:0]         sonar_q, sonar_d;
	logic [1:0]         hits_q, hits_d;
	logic               dwell_active_q, dwell_active_d;
	logic [8:0]         dwell_timer_q, dwell_timer_d;
	logic [15:0]        station_total_q, station_total_d;
	logic [1:0]         heading_q, heading_d;

	logic               advance;
	logic [11:0]        holdoff_inc;
	logic [5:0]         sonar_inc;
	logic               running, armed, sample_due, in_range;
	logic [1:0]         hits_upd;
	logic               obstacle_go, station_go;
	logic [2:0]         blacks;
	logic               wide;
	logic [8:0]         dwell_upd;
	logic signed [3:0]  err;
	logic [12:0]        slow_num;
	logic [25:0]        slow_prod;
	logic [9:0]         base;
	logic signed [7:0]  turn;
	logic signed [11:0] track_left, track_right;
	logic [15:0]        timer_inc;
	logic [5:0]         stop_eff;
	logic [15:0]        dwell_dur;
	logic signed [11:0] left_d, right_d;
	logic [1:0]         mode_d;

	// apb configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_speed_q <= RUN_SPEED_RESET;
			stop_time_q <= STOP_TIME_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_RUN_SPEED: run_speed_q <= pwdata[9:0];
				REG_STOP_TIME: stop_time_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RUN_SPEED: prdata = {22'd0, run_speed_q};
			REG_STOP_TIME: prdata = {26'd0, stop_time_q};
			default:       prdata = 32'd0;
		endcase
	end

	// handshake
	assign advance    = valid_s1 && (!valid_s2 || drive.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			sensors_s1  <= tick.line_sensors;
			distance_s1 <= tick.distance_mm;
		end
	end

	// shared decode
	always_comb begin
		holdoff_inc = (holdoff_q <= HOLDOFF_TICKS) ? holdoff_q + 12'd1 : holdoff_q;
		sonar_inc   = (sonar_q < SONAR_PERIOD) ? sonar_q + 6'd1 : sonar_q;
		running     = (phase_q == PH_RUN);
		armed       = running && (holdoff_inc > HOLDOFF_TICKS);
		sample_due  = armed && (sonar_inc >= SONAR_PERIOD);
		in_range    = (distance_s1 > NEAR_MIN_MM) && (distance_s1 < NEAR_MAX_MM);
		if (!sample_due) begin
			hits_upd = hits_q;
		end else if (!in_range) begin
			hits_upd = 2'd0;
		end else if (hits_q < HITS_NEEDED) begin
			hits_upd = hits_q + 2'd1;
		end else begin
			hits_upd = hits_q;
		end
		obstacle_go = armed && (hits_upd >= HITS_NEEDED);

		blacks = {2'd0, sensors_s1[0]} + {2'd0, sensors_s1[1]} + {2'd0, sensors_s1[2]}
			+ {2'd0, sensors_s1[3]} + {2'd0, sensors_s1[4]};
		wide = (blacks >= 3'd3);
		if (!dwell_active_q) begin
			dwell_upd = 9'd0;
		end else if (dwell_timer_q < DWELL_RUN_MAX) begin
			dwell_upd = dwell_timer_q + 9'd1;
		end else begin
			dwell_upd = dwell_timer_q;
		end
		station_go = running && !obstacle_go && wide && (dwell_upd > DWELL_TICKS);

		if (sensors_s1 == 5'd0) begin
			err = (prev_err_q < 0) ? -4'sd5 : 4'sd5;
		end else if (sensors_s1[2]) begin
			err = sensors_s1[1] ? -4'sd1 : (sensors_s1[3] ? 4'sd1 : 4'sd0);
		end else if (sensors_s1[1]) begin
			err = sensors_s1[0] ? -4'sd3 : -4'sd2;
		end else if (sensors_s1[3]) begin
			err = sensors_s1[4] ? 4'sd3 : 4'sd2;
		end else if (sensors_s1[0]) begin
			err = -4'sd4;
		end else begin
			err = 4'sd4;
		end

		slow_num  = {3'd0, run_speed_q} * SLOW_NUM;
		slow_prod = {13'd0, slow_num} * DIV10_RECIP;
		base      = (err >= 4'sd4 || err <= -4'sd4) ? slow_prod[25:16] : run_speed_q;
		turn      = {{4{err[3]}}, err} * TURN_GAIN;
		track_left  = $signed({2'd0, base}) + {{4{turn[7]}}, turn};
		track_right = $signed({2'd0, base}) - {{4{turn[7]}}, turn};

		timer_inc = phase_timer_q + 16'd1;
		stop_eff  = (stop_time_q == 6'd0) ? 6'd1 : stop_time_q;
		dwell_dur = {10'd0, stop_eff} * TICKS_PER_SEC;
	end

	// next state
	always_comb begin
		phase_d         = phase_q;
		phase_timer_d   = phase_timer_q;
		prev_err_d      = prev_err_q;
		holdoff_d       = holdoff_inc;
		sonar_d         = sample_due ? 6'd0 : sonar_inc;
		hits_d          = hits_upd;
		dwell_active_d  = dwell_active_q;
		dwell_timer_d   = dwell_timer_q;
		station_total_d = station_total_q;
		heading_d       = heading_q;
		case (phase_q)
			PH_RUN: begin
				if (obstacle_go) begin
					hits_d         = 2'd0;
					dwell_active_d = 1'b0;
					dwell_timer_d  = 9'd0;
					phase_d        = PH_OB_STOP;
					phase_timer_d  = 16'd1;
				end else if (station_go) begin
					dwell_active_d  = 1'b0;
					dwell_timer_d   = 9'd0;
					station_total_d = station_total_q + 16'd1;
					phase_d         = PH_DWELL;
					phase_timer_d   = 16'd1;
				end else begin
					dwell_active_d = wide;
					dwell_timer_d  = wide ? dwell_upd : 9'd0;
					if (sensors_s1 != 5'd0) begin
						prev_err_d = err;
					end
					if (err == 4'sd0) begin
						heading_d = HEAD_FWD;
					end else if (err < 0) begin
						heading_d = HEAD_LEFT;
					end else begin
						heading_d = HEAD_RIGHT;
					end
				end
			end
			PH_DWELL: begin
				phase_d       = (timer_inc >= dwell_dur) ? PH_EXIT : PH_DWELL;
				phase_timer_d = (timer_inc >= dwell_dur) ? 16'd0 : timer_inc;
			end
			PH_EXIT: begin
				phase_d       = (timer_inc >= EXIT_TICKS) ? PH_RUN : PH_EXIT;
				phase_timer_d = (timer_inc >= EXIT_TICKS) ? 16'd0 : timer_inc;
			end
			PH_OB_STOP: begin
				phase_d       = (timer_inc >= OB_STOP_TICKS) ? PH_OB_SPIN : PH_OB_STOP;
				phase_timer_d = (timer_inc >= OB_STOP_TICKS) ? 16'd0 : timer_inc;
			end
			PH_OB_SPIN: begin
				phase_d       = (timer_inc >= OB_SPIN_TICKS) ? PH_OB_ARC : PH_OB_SPIN;
				phase_timer_d = (timer_inc >= OB_SPIN_TICKS) ? 16'd0 : timer_inc;
			end
			PH_OB_ARC: begin
				phase_d       = (timer_inc >= OB_ARC_TICKS) ? PH_OB_SEARCH : PH_OB_ARC;
				phase_timer_d = (timer_inc >= OB_ARC_TICKS) ? 16'd0 : timer_inc;
			end
			PH_OB_SEARCH: begin
				if (sensors_s1 != 5'd0) begin
					phase_d       = PH_OB_BACK;
					phase_timer_d = 16'd1;
				end else if (timer_inc >= SEARCH_LIMIT_TICKS) begin
					phase_d       = PH_RUN;
					phase_timer_d = 16'd0;
					holdoff_d     = 12'd0;
					hits_d        = 2'd0;
				end else begin
					phase_timer_d = timer_inc;
				end
			end
			PH_OB_BACK: begin
				if (timer_inc >= OB_BACK_TICKS) begin
					phase_d       = PH_RUN;
					phase_timer_d = 16'd0;
					holdoff_d     = 12'd0;
					hits_d        = 2'd0;
				end else begin
					phase_timer_d = timer_inc;
				end
			end
			default: ;
		endcase
	end

	// drive outputs
	always_comb begin
		left_d  = 12'sd0;
		right_d = 12'sd0;
		mode_d  = MODE_AVOID;
		case (phase_q)
			PH_RUN: begin
				if (obstacle_go) begin
					mode_d = MODE_AVOID;
				end else if (station_go) begin
					mode_d = MODE_STATION;
				end else begin
					left_d  = track_left;
					right_d = track_right;
					mode_d  = MODE_RUN;
				end
			end
			PH_DWELL: mode_d = MODE_STATION;
			PH_EXIT: begin
				left_d  = $signed({2'd0, run_speed_q});
				right_d = $signed({2'd0, run_speed_q});
				mode_d  = MODE_RUN;
			end
			PH_OB_STOP: ;
			PH_OB_SPIN: begin
				left_d  = -OB_SPIN_DRIVE;
				right_d = OB_SPIN_DRIVE;
			end
			PH_OB_ARC: begin
				left_d  = OB_OUTER;
				right_d = OB_INNER;
			end
			PH_OB_SEARCH: begin
				left_d  = (sensors_s1 != 5'd0) ? -OB_BACK_DRIVE : OB_OUTER;
				right_d = (sensors_s1 != 5'd0) ? -OB_BACK_DRIVE : OB_INNER;
			end
			PH_OB_BACK: begin
				left_d  = -OB_BACK_DRIVE;
				right_d = -OB_BACK_DRIVE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_RUN;
			phase_timer_q   <= 16'd0;
			prev_err_q      <= 4'sd0;
			holdoff_q       <= 12'd0;
			sonar_q         <= 6'd0;
			hits_q          <= 2'd0;
			dwell_active_q  <= 1'b0;
			dwell_timer_q   <= 9'd0;
			station_total_q <= 16'd0;
			heading_q       <= HEAD_FWD;
		end else if (advance) begin
			phase_q         <= phase_d;
			phase_timer_q   <= phase_timer_d;
			prev_err_q      <= prev_err_d;
			holdoff_q       <= holdoff_d;
			sonar_q         <= sonar_d;
			hits_q          <= hits_d;
			dwell_active_q  <= dwell_active_d;
			dwell_timer_q   <= dwell_timer_d;
			station_total_q <= station_total_d;
			heading_q       <= heading_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || drive.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2     <= left_d;
			right_s2    <= right_d;
			heading_s2  <= heading_d;
			mode_s2     <= mode_d;
			stations_s2 <= station_total_d;
		end
	end

	assign drive.valid         = valid_s2;
	assign drive.left_drive    = left_s2;
	assign drive.right_drive   = right_s2;
	assign drive.heading       = heading_s2;
	assign drive.car_mode      = mode_s2;
	assign drive.stations_seen = stations_s2;

	a_holdoff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		holdoff_q <= HOLDOFF_SAT)
		else $error("holdoff timer beyond saturation");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(station_total_q) && $stable(hits_q))
		else $error("state changed without a transaction");

	a_station_entry: assert property (@(posedge clk) disable iff (!arst_n)
		advance && station_go |=> phase_q == PH_DWELL)
		else $error("station count without dwell entry");

	a_station_still: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && mode_s2 == MODE_STATION |-> left_s2 == 12'sd0 && right_s2 == 12'sd0)
		else $error("wheels moving during station dwell");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> valid_s1 && valid_s2 && !drive.ready)
		else $error("input stalled with room in the pipeline");

endmodule

[test/tb_top.sv]
// regression bench for line_follow_drive_controller: sensor ticks in, wheel drive results out
// a cycle-free model of the tracking, station and obstacle phases predicts every result but those of
// the typed directed ticks, which carry hand-written results; depends on lfdc_pkg, lfdc_channels and the controller rtl
module tb_top;
	import lfdc_pkg::*;

	typedef struct packed {
		logic signed [11:0] left_drv;
		logic signed [11:0] right_drv;
		logic [1:0]         heading;
		logic [1:0]         mode;
		logic [15:0]        stations;
	} drive_res_t;

	typedef struct {
		logic [4:0]  sensors;
		logic [11:0] dist_mm;
		bit          typed;
		drive_res_t  res;
	} tick_row_t;

	typedef enum logic [2:0] {
		PAT_TRACK,
		PAT_LOST,
		PAT_BLACK,
		PAT_NEAR,
		PAT_NOISE
	} road_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lfdc_tick_if  tick_ch ();
	lfdc_drive_if drive_ch ();

	line_follow_drive_controller u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.drive   (drive_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         mismatches = 0;
	drive_res_t expected_drives[$];

	// predictor copy of configuration and state
	logic [9:0]         cfg_speed = RUN_SPEED_RESET;
	logic [5:0]         cfg_stop_s = STOP_TIME_RESET;
	phase_t             ph = PH_RUN;
	logic [15:0]        ph_cnt = '0;
	logic signed [3:0]  last_err = '0;
	logic [11:0]        hold_cnt = '0;
	logic [5:0]         sonar_cnt = '0;
	logic [1:0]         near_hits = '0;
	bit                 run_on = 1'b0;
	logic [8:0]         run_cnt = '0;
	logic [15:0]        stn_total = '0;
	logic [1:0]         head_now = HEAD_FWD;

	tick_row_t directed_ticks [21] = '{
		'{5'b00100, 12'd2000, 1'b1, '{12'sd300, 12'sd300, HEAD_FWD, MODE_RUN, 16'd0}},
		'{5'b00110, 12'd2000, 1'b1, '{12'sd275, 12'sd325, HEAD_LEFT, MODE_RUN, 16'd0}},
		'{5'b01100, 12'd2000, 1'b1, '{12'sd325, 12'sd275, HEAD_RIGHT, MODE_RUN, 16'd0}},
		'{5'b00010, 12'd2000, 1'b1, '{12'sd250, 12'sd350, HEAD_LEFT, MODE_RUN, 16'd0}},
		'{5'b00011, 12'd2000, 1'b1, '{12'sd225, 12'sd375, HEAD_LEFT, MODE_RUN, 16'd0}},
		'{5'b01000, 12'd2000, 1'b1, '{12'sd350, 12'sd250, HEAD_RIGHT, MODE_RUN, 16'd0}},
		'{5'b11000, 12'd2000, 1'b1, '{12'sd375, 12'sd225, HEAD_RIGHT, MODE_RUN, 16'd0}},
		'{5'b00001, 12'd2000, 1'b1, '{12'sd110, 12'sd310, HEAD_LEFT, MODE_RUN, 16'd0}},
		'{5'b00000, 12'd0, 1'b1, '{12'sd85, 12'sd335, HEAD_LEFT, MODE_RUN, 16'd0}},
		'{5'b10000, 12'd2000, 1'b1, '{12'sd310, 12'sd110, HEAD_RIGHT, MODE_RUN, 16'd0}},
		'{5'b00000, 12'd4095, 1'b1, '{12'sd335, 12'sd85, HEAD_RIGHT, MODE_RUN, 16'd0}},
		'{5'b00100, 12'd0, 1'b1, '{12'sd300, 12'sd300, HEAD_FWD, MODE_RUN, 16'd0}},
		'{5'b00100, 12'd4095, 1'b1, '{12'sd300, 12'sd300, HEAD_FWD, MODE_RUN, 16'd0}},
		'{5'b11111, 12'd149, 1'b0, '0},
		'{5'b00111, 12'd11, 1'b0, '0},
		'{5'b00100, 12'd10, 1'b0, '0},
		'{5'b11100, 12'd150, 1'b0, '0},
		'{5'b10001, 12'd4095, 1'b0, '0},
		'{5'b01010, 12'd0, 1'b0, '0},
		'{5'b11111, 12'd1, 1'b0, '0},
		'{5'b00000, 12'd2048, 1'b0, '0}
	};

	function automatic void count_phase(input int dur, input phase_t nxt);
		ph_cnt++;
		if (ph_cnt >= dur) begin
			ph = nxt;
			ph_cnt = '0;
		end
	endfunction

	function automatic void finish_avoid();
		ph = PH_RUN;
		ph_cnt = '0;
		hold_cnt = '0;
		near_hits = '0;
	endfunction

	function automatic void phase_drive(input logic [4:0] s, output int l, output int r,
		output logic [1:0] mode);
		int dur;
		case (ph)
			PH_DWELL: begin
				l = 0;
				r = 0;
				mode = MODE_STATION;
				dur = (cfg_stop_s == 0 ? 1 : int'(cfg_stop_s)) * int'(TICKS_PER_SEC);
				count_phase(dur, PH_EXIT);
			end
			PH_EXIT: begin
				l = int'(cfg_speed);
				r = int'(cfg_speed);
				mode = MODE_RUN;
				count_phase(int'(EXIT_TICKS), PH_RUN);
			end
			PH_OB_STOP: begin
				l = 0;
				r = 0;
				mode = MODE_AVOID;
				count_phase(int'(OB_STOP_TICKS), PH_OB_SPIN);
			end
			PH_OB_SPIN: begin
				l = -int'(OB_SPIN_DRIVE);
				r = int'(OB_SPIN_DRIVE);
				mode = MODE_AVOID;
				count_phase(int'(OB_SPIN_TICKS), PH_OB_ARC);
			end
			PH_OB_ARC: begin
				l = int'(OB_OUTER);
				r = int'(OB_INNER);
				mode = MODE_AVOID;
				count_phase(int'(OB_ARC_TICKS), PH_OB_SEARCH);
			end
			PH_OB_SEARCH: begin
				mode = MODE_AVOID;
				if (s != 0) begin
					ph = PH_OB_BACK;
					ph_cnt = 16'd1;
					l = -int'(OB_BACK_DRIVE);
					r = -int'(OB_BACK_DRIVE);
				end else begin
					l = int'(OB_OUTER);
					r = int'(OB_INNER);
					ph_cnt++;
					if (ph_cnt >= SEARCH_LIMIT_TICKS)
						finish_avoid();
				end
			end
			default: begin
				l = -int'(OB_BACK_DRIVE);
				r = -int'(OB_BACK_DRIVE);
				mode = MODE_AVOID;
				ph_cnt++;
				if (ph_cnt >= OB_BACK_TICKS)
					finish_avoid();
			end
		endcase
	endfunction

	function automatic drive_res_t predict_drive(input logic [4:0] s, input logic [11:0] d);
		int         l;
		int         r;
		int         err;
		int         base;
		logic [1:0] mode;
		bit         handled;
		drive_res_t res;
		l = 0;
		r = 0;
		err = 0;
		mode = MODE_RUN;
		handled = 1'b0;
		if (hold_cnt <= HOLDOFF_TICKS)
			hold_cnt++;
		if (sonar_cnt < SONAR_PERIOD)
			sonar_cnt++;
		if (ph != PH_RUN) begin
			phase_drive(s, l, r, mode);
			handled = 1'b1;
		end
		if (!handled && hold_cnt > HOLDOFF_TICKS) begin
			if (sonar_cnt >= SONAR_PERIOD) begin
				sonar_cnt = '0;
				if (d > NEAR_MIN_MM && d < NEAR_MAX_MM) begin
					if (near_hits < HITS_NEEDED)
						near_hits++;
				end else begin
					near_hits = '0;
				end
			end
			if (near_hits >= HITS_NEEDED) begin
				near_hits = '0;
				run_on = 1'b0;
				run_cnt = '0;
				ph = PH_OB_STOP;
				ph_cnt = '0;
				phase_drive(s, l, r, mode);
				handled = 1'b1;
			end
		end
		if (!handled) begin
			if ($countones(s) >= 3) begin
				if (!run_on) begin
					run_on = 1'b1;
					run_cnt = '0;
				end else if (run_cnt < DWELL_RUN_MAX) begin
					run_cnt++;
				end
				if (run_cnt > DWELL_TICKS) begin
					run_on = 1'b0;
					run_cnt = '0;
					stn_total++;
					ph = PH_DWELL;
					ph_cnt = '0;
					phase_drive(s, l, r, mode);
					handled = 1'b1;
				end
			end else begin
				run_on = 1'b0;
				run_cnt = '0;
			end
		end
		if (!handled) begin
			if (s != 0) begin
				if (s[2])
					err = s[1] ? -1 : (s[3] ? 1 : 0);
				else if (s[1])
					err = s[0] ? -3 : -2;
				else if (s[3])
					err = s[4] ? 3 : 2;
				else if (s[0])
					err = -4;
				else
					err = 4;
				last_err = err[3:0];
			end else begin
				err = (last_err < 0) ? -5 : 5;
			end
			base = int'(cfg_speed);
			if (err >= 4 || err <= -4)
				base = base * 7 / 10;
			l = base + err * int'(TURN_GAIN);
			r = base - err * int'(TURN_GAIN);
			mode = MODE_RUN;
			head_now = (err == 0) ? HEAD_FWD : (err < 0 ? HEAD_LEFT : HEAD_RIGHT);
		end
		res.left_drv = l[11:0];
		res.right_drv = r[11:0];
		res.heading = head_now;
		res.mode = mode;
		res.stations = stn_total;
		return res;
	endfunction

	task automatic report(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	task automatic send_tick(input logic [4:0] s, input logic [11:0] d, input bit typed,
		input drive_res_t typed_res);
		drive_res_t res;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.line_sensors <= s;
		tick_ch.distance_mm <= d;
		do @(posedge clk); while (!tick_ch.ready);
		res = predict_drive(s, d);
		expected_drives.push_back(typed ? typed_res : res);
	endtask

	task automatic wait_drain();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_drives.size() != 0);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_RUN_SPEED)
			cfg_speed = value[9:0];
		else
			cfg_stop_s = value[5:0];
		@(posedge clk);
	endtask

	function automatic logic [4:0] line_shape();
		case ($urandom_range(0, 8))
			0: return 5'b00100;
			1: return 5'b00110;
			2: return 5'b01100;
			3: return 5'b00010;
			4: return 5'b00011;
			5: return 5'b01000;
			6: return 5'b11000;
			7: return 5'b00001;
			default: return 5'b10000;
		endcase
	endfunction

	task automatic run_phase(input int budget, input int black_cap, input bit long_search,
		input bit live_write);
		int            n;
		int            seg_left;
		int            blacks_used;
		int            search_goal;
		int            r;
		road_pattern_t kind;
		logic [4:0]    s;
		logic [11:0]   d;
		n = 0;
		seg_left = 0;
		blacks_used = 0;
		search_goal = 0;
		kind = PAT_TRACK;
		while (n < budget || ph != PH_RUN) begin
			// stop time rewritten in the middle of a station dwell
			if (live_write && ph == PH_DWELL && ph_cnt >= 700) begin
				wait_drain();
				reg_write(REG_STOP_TIME, 32'($urandom_range(0, 1)));
				live_write = 1'b0;
			end
			if (ph == PH_OB_SEARCH) begin
				if (ph_cnt == 0) begin
					search_goal = long_search ? int'(SEARCH_LIMIT_TICKS)
						: int'($urandom_range(0, 300));
					long_search = 1'b0;
				end
				s = (ph_cnt >= search_goal) ? 5'($urandom_range(1, 31)) : 5'd0;
				d = 12'($urandom);
				seg_left = 0;
			end else if (ph != PH_RUN) begin
				s = 5'($urandom);
				d = 12'($urandom);
				seg_left = 0;
			end else begin
				if (seg_left == 0) begin
					r = $urandom_range(0, 99);
					if (blacks_used == 0 && black_cap > 0)
						kind = PAT_BLACK;
					else if (hold_cnt > HOLDOFF_TICKS && $urandom_range(0, 2) == 0)
						kind = PAT_NEAR;
					else if (r < 45)
						kind = PAT_TRACK;
					else if (r < 55)
						kind = PAT_LOST;
					else if (r < 63)
						kind = PAT_BLACK;
					else if (r < 75)
						kind = PAT_NEAR;
					else
						kind = PAT_NOISE;
					if (kind == PAT_BLACK) begin
						if (blacks_used >= black_cap)
							kind = PAT_TRACK;
						else
							blacks_used++;
					end
					case (kind)
						PAT_TRACK: seg_left = $urandom_range(20, 200);
						PAT_LOST: seg_left = $urandom_range(1, 20);
						PAT_BLACK: seg_left = (blacks_used == 1) ? $urandom_range(185, 200)
							: $urandom_range(170, 200);
						PAT_NEAR: seg_left = $urandom_range(30, 130);
						default: seg_left = $urandom_range(1, 30);
					endcase
				end
				case (kind)
					PAT_TRACK: begin
						s = ($urandom_range(0, 9) == 0) ? 5'($urandom) : line_shape();
						d = 12'($urandom_range(150, 4095));
					end
					PAT_LOST: begin
						s = 5'd0;
						d = 12'($urandom);
					end
					PAT_BLACK: begin
						do s = 5'($urandom); while ($countones(s) < 3);
						d = 12'($urandom_range(150, 4095));
					end
					PAT_NEAR: begin
						s = $urandom_range(0, 1) ? line_shape() : 5'($urandom);
						if ($urandom_range(0, 19) == 0)
							d = $urandom_range(0, 1) ? NEAR_MIN_MM : NEAR_MAX_MM;
						else
							d = 12'($urandom_range(11, 149));
					end
					default: begin
						s = 5'($urandom);
						d = 12'($urandom);
					end
				endcase
				seg_left--;
			end
			send_tick(s, d, 1'b0, '0);
			n++;
			if ($urandom_range(0, 1999) == 0)
				wait_drain();
		end
	endtask

	always @(posedge clk) begin
		drive_res_t got;
		drive_res_t want;
		drive_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			got = '{drive_ch.left_drive, drive_ch.right_drive, drive_ch.heading,
				drive_ch.car_mode, drive_ch.stations_seen};
			if (expected_drives.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				want = expected_drives.pop_front();
				if (got.left_drv !== want.left_drv)
					report("left_drive", got.left_drv, want.left_drv);
				if (got.right_drv !== want.right_drv)
					report("right_drive", got.right_drv, want.right_drv);
				if (got.heading !== want.heading)
					report("heading", got.heading, want.heading);
				if (got.mode !== want.mode)
					report("car_mode", got.mode, want.mode);
				if (got.stations !== want.stations)
					report("stations_seen", got.stations, want.stations);
			end
		end
	end

	initial begin
		#8000000;
		$display("line_follow_drive_controller regression: fail");
		$finish;
	end

	initial begin
		int speed;
		int stop;
		int cap;
		tick_ch.valid = 1'b0;
		tick_ch.line_sensors = '0;
		tick_ch.distance_mm = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_ticks[i])
			send_tick(directed_ticks[i].sensors, directed_ticks[i].dist_mm,
				directed_ticks[i].typed, directed_ticks[i].res);

		for (int p = 0; p < 5; p++) begin
			wait_drain();
			cap = 0;
			case (p)
				0: begin
					speed = 1000;
					stop = 0;
					cap = 1;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					speed = 0;
					stop = 1;
					send_idle_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					speed = $urandom_range(1, 999);
					stop = 2;
					send_idle_pct = 0;
					recv_stall_pct = 77;
				end
				3: begin
					speed = $urandom_range(0, 1000);
					stop = 3;
					send_idle_pct = 9;
					recv_stall_pct = 9;
				end
				default: begin
					speed = $urandom_range(0, 1000);
					stop = 60;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			reg_write(REG_RUN_SPEED, 32'(speed));
			reg_write(REG_STOP_TIME, 32'(stop));
			run_phase((p == 0) ? 200 : 90, cap, p == 0, p == 0);
		end

		wait_drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("line_follow_drive_controller regression: pass");
		else
			$display("line_follow_drive_controller regression: fail");
		$finish;
	end

endmodule
